// ----- sv/jakc_pkg.sv -----
package jakc_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int POS_W     = 18;
  localparam int EST_OUT_W = 12;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam int PQ_W      = 32;
  localparam int DEN_W     = 34;
  localparam int LIM_W     = 12;
  localparam int GAIN_W    = 16;
  localparam int OUT_W     = 16;
  localparam int K_W       = 16;
  localparam int SCALED_W  = 14;
  localparam int SPAN_W    = 16;

  localparam int MUL_N     = 17;
  localparam int DIV_N     = 30;
  localparam int CNT_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE_Q    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_R    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P_INIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CENTER = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd7;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_PREP = 15'b000000000000010,
    S_KSET = 15'b000000000000100,
    S_KDIV = 15'b000000000001000,
    S_KFIN = 15'b000000000010000,
    S_UPD  = 15'b000000000100000,
    S_EFIN = 15'b000000001000000,
    S_COND = 15'b000000010000000,
    S_GMUL = 15'b000000100000000,
    S_SSET = 15'b000001000000000,
    S_SMUL = 15'b000010000000000,
    S_DSET = 15'b000100000000000,
    S_ODIV = 15'b001000000000000,
    S_PFIN = 15'b010000000000000,
    S_DONE = 15'b100000000000000
  } state_t;

endpackage

// ----- sv/jakc_sample_if.sv -----
interface jakc_sample_if import jakc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink (input valid, input mode, input sample, output ready);
endinterface

// ----- sv/jakc_result_if.sv -----
interface jakc_result_if import jakc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [POS_W-1:0] position;
  logic [EST_OUT_W-1:0]  estimate;

  modport source (output valid, output position, output estimate, input ready);
  modport sink (input valid, input position, input estimate, output ready);
endinterface

// ----- sv/joystick_axis_kalman_conditioner.sv -----
// Joystick axis conditioner: a scalar Kalman filter on each ADC sample, then
// center, dead zone, clamp to +-max_range, gain and linear mapping to the
// output scale. One result per input transfer. A new sample is taken only
// in the idle state, after the last one has reached the output register.
// The gain division and the output division run on one bit-serial
// restoring divider, and the estimate/covariance update, the gain scaling
// and the span scaling run on bit-serial shift-add multipliers. A calibrate
// item skips the filter. A finished result sits in the output register, so
// the next sample can be taken while it waits. Write the
// configuration registers only while the block is idle.
module joystick_axis_kalman_conditioner import jakc_pkg::*; #(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  jakc_sample_if.sink          samples,
  jakc_result_if.source        results
);

  localparam int EW = ADC_BITS + FRAC_BITS;
  localparam int CW = ((ADC_BITS > LIM_W) ? ADC_BITS : LIM_W) + 1;
  localparam logic [ADC_BITS-1:0] MID = {1'b1, {(ADC_BITS-1){1'b0}}};

  // configuration
  logic [PQ_W-1:0]          noise_q, noise_r, p_init;
  logic [LIM_W-1:0]         deadband, max_range;
  logic signed [OUT_W-1:0]  out_min, out_center;
  logic [GAIN_W-1:0]        gain;

  // filter state
  logic [EW-1:0]            estimate_q;
  logic [PQ_W-1:0]          covariance;
  logic [ADC_BITS-1:0]      center_point;

  state_t                   state;
  logic [CNT_W-1:0]         cnt;
  logic [ADC_BITS-1:0]      smp;
  logic [EW-1:0]            diff;
  logic                     diff_neg;
  logic [PQ_W-1:0]          p_r;
  logic                     den_zero;

  logic [EW-1:0]            mul_mcand, mul_hi;
  logic [MUL_N-1:0]         mul_lo;
  logic [PQ_W-1:0]          cm_hi;
  logic [MUL_N-1:0]         cm_lo;

  logic [DEN_W-1:0]         div_rem, div_dsr;
  logic [DIV_N-1:0]         div_dvd, div_quo;

  logic                     res_neg;
  logic [SPAN_W-1:0]        span_mag_r;
  logic signed [POS_W-1:0]  res_pos;

  logic                     out_valid;
  logic signed [POS_W-1:0]  out_pos;
  logic [EST_OUT_W-1:0]     out_est;

  // combinational
  logic [ADC_BITS-1:0]      sample_m;
  logic [EW-1:0]            target;
  logic [PQ_W:0]            p_sum;
  logic [PQ_W-1:0]          p_sat;
  logic [DEN_W-1:0]         den;
  logic [EW:0]              mul_sum;
  logic [PQ_W:0]            cm_sum;
  logic [DEN_W:0]           div_trial, div_sub;
  logic                     div_ge;
  logic [DEN_W-1:0]         div_rem_step;
  logic [K_W-1:0]           k_val;
  logic [EW-1:0]            est_step;
  logic [PQ_W-1:0]          cov_new;
  logic [ADC_BITS-1:0]      est_int;
  logic [ADC_BITS:0]        dev, dev_abs;
  logic                     dev_neg, in_dz;
  logic [CW-1:0]            abs_c, dz_c, lim_c, mag_c;
  logic [LIM_W-1:0]         mag;
  logic signed [SPAN_W:0]   span;
  logic                     span_neg;
  logic [SPAN_W-1:0]        span_mag;
  logic [SCALED_W-1:0]      scaled;
  logic [DIV_N-1:0]         span_prod;
  logic signed [31:0]       q_ext, q_signed, pos_sum;
  logic signed [POS_W-1:0]  pos_sat, center_pos;
  logic                     mul_run;

  always_comb begin
    sample_m  = ADC_BITS'(samples.sample);
    target    = {smp, {FRAC_BITS{1'b0}}};
    p_sum     = {1'b0, covariance} + {1'b0, noise_q};
    p_sat     = p_sum[PQ_W] ? {PQ_W{1'b1}} : p_sum[PQ_W-1:0];
    den       = DEN_W'(p_r) + DEN_W'(noise_r);

    mul_sum   = {1'b0, mul_hi} + (mul_lo[0] ? {1'b0, mul_mcand} : '0);
    cm_sum    = {1'b0, cm_hi} + (cm_lo[0] ? {1'b0, p_r} : '0);

    div_trial    = {div_rem, div_dvd[DIV_N-1]};
    div_sub      = div_trial - {1'b0, div_dsr};
    div_ge       = div_trial >= {1'b0, div_dsr};
    div_rem_step = div_ge ? div_sub[DEN_W-1:0] : div_trial[DEN_W-1:0];

    if (den_zero) begin
      k_val = '0;
    end else if (div_quo[DIV_N-1:K_W] != '0) begin
      k_val = {K_W{1'b1}};
    end else begin
      k_val = div_quo[K_W-1:0];
    end

    est_step = {mul_hi[EW-2:0], mul_lo[MUL_N-1]};
    cov_new  = {cm_hi[PQ_W-2:0], cm_lo[MUL_N-1]};

    est_int  = estimate_q[EW-1:FRAC_BITS];
    dev      = {1'b0, est_int} - {1'b0, center_point};
    dev_abs  = dev[ADC_BITS] ? (~dev + 1'b1) : dev;
    abs_c    = CW'(dev_abs[ADC_BITS-1:0]);
    dz_c     = CW'(deadband);
    lim_c    = CW'(max_range);
    in_dz    = abs_c < dz_c;
    mag_c    = in_dz ? '0 : ((abs_c > lim_c) ? lim_c : abs_c);
    mag      = mag_c[LIM_W-1:0];
    dev_neg  = dev[ADC_BITS] && !in_dz;

    span     = $signed({5'b0, max_range}) - (SPAN_W+1)'(out_min);
    span_neg = span[SPAN_W];
    span_mag = span_neg ? SPAN_W'(-span) : span[SPAN_W-1:0];

    scaled    = {mul_hi[10:0], mul_lo[MUL_N-1:MUL_N-3]};
    span_prod = {mul_hi[12:0], mul_lo};

    q_ext      = $signed({2'b0, div_quo});
    q_signed   = res_neg ? -q_ext : q_ext;
    pos_sum    = 32'(out_center) + q_signed;
    center_pos = POS_W'(out_center);
    if (pos_sum > 32'sd131071) begin
      pos_sat = {1'b0, {(POS_W-1){1'b1}}};
    end else if (pos_sum < -32'sd131072) begin
      pos_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      pos_sat = pos_sum[POS_W-1:0];
    end

    mul_run = (state == S_UPD) || (state == S_GMUL) || (state == S_SMUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_q    <= 32'd655;
      noise_r    <= 32'd65536;
      p_init     <= 32'd65536;
      deadband   <= 12'd10;
      max_range  <= 12'd100;
      out_min    <= -16'sd100;
      out_center <= 16'sd0;
      gain       <= 16'd16384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NOISE_Q:    noise_q    <= cfg_data;
        REG_NOISE_R:    noise_r    <= cfg_data;
        REG_P_INIT:     p_init     <= cfg_data;
        REG_DEADBAND:   deadband   <= cfg_data[LIM_W-1:0];
        REG_MAX_RANGE:  max_range  <= cfg_data[LIM_W-1:0];
        REG_OUT_MIN:    out_min    <= $signed(cfg_data[OUT_W-1:0]);
        REG_OUT_CENTER: out_center <= $signed(cfg_data[OUT_W-1:0]);
        REG_GAIN:       gain       <= cfg_data[GAIN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_run) begin
      mul_hi <= mul_sum[EW:1];
      mul_lo <= {mul_sum[0], mul_lo[MUL_N-1:1]};
      cm_hi  <= cm_sum[PQ_W:1];
      cm_lo  <= {cm_sum[0], cm_lo[MUL_N-1:1]};
    end
    if ((state == S_KDIV) || (state == S_ODIV)) begin
      div_rem <= div_rem_step;
      div_dvd <= {div_dvd[DIV_N-2:0], 1'b0};
      div_quo <= {div_quo[DIV_N-2:0], div_ge};
    end

    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      estimate_q   <= {MID, {FRAC_BITS{1'b0}}};
      covariance   <= 32'd65536;
      center_point <= MID;
    end else begin
      if (out_valid && results.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            smp <= sample_m;
            if (samples.mode) begin
              center_point <= sample_m;
              estimate_q   <= {sample_m, {FRAC_BITS{1'b0}}};
              covariance   <= p_init;
              res_pos      <= center_pos;
              state        <= S_DONE;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          p_r <= p_sat;
          if (target >= estimate_q) begin
            diff     <= target - estimate_q;
            diff_neg <= 1'b0;
          end else begin
            diff     <= estimate_q - target;
            diff_neg <= 1'b1;
          end
          state <= S_KSET;
        end
        S_KSET: begin
          div_dsr  <= den;
          den_zero <= (den == '0);
          div_rem  <= DEN_W'(p_r[PQ_W-1:1]);
          div_dvd  <= {p_r[0], {(DIV_N-1){1'b0}}};
          div_quo  <= '0;
          cnt      <= CNT_W'(MUL_N - 1);
          state    <= S_KDIV;
        end
        S_KDIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_KFIN;
          end
        end
        S_KFIN: begin
          mul_mcand <= diff;
          mul_hi    <= '0;
          mul_lo    <= {1'b0, k_val};
          cm_hi     <= '0;
          cm_lo     <= {1'b1, {K_W{1'b0}}} - {1'b0, k_val};
          cnt       <= CNT_W'(MUL_N - 1);
          state     <= S_UPD;
        end
        S_UPD: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_EFIN;
          end
        end
        S_EFIN: begin
          estimate_q <= diff_neg ? (estimate_q - est_step) : (estimate_q + est_step);
          covariance <= cov_new;
          state      <= S_COND;
        end
        S_COND: begin
          if (max_range == '0) begin
            res_pos <= center_pos;
            state   <= S_DONE;
          end else begin
            mul_mcand  <= EW'(mag);
            mul_hi     <= '0;
            mul_lo     <= {1'b0, gain};
            res_neg    <= dev_neg ^ span_neg;
            span_mag_r <= span_mag;
            cnt        <= CNT_W'(MUL_N - 1);
            state      <= S_GMUL;
          end
        end
        S_GMUL: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_SSET;
          end
        end
        S_SSET: begin
          mul_mcand <= EW'(span_mag_r);
          mul_hi    <= '0;
          mul_lo    <= MUL_N'(scaled);
          cnt       <= CNT_W'(MUL_N - 1);
          state     <= S_SMUL;
        end
        S_SMUL: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_DSET;
          end
        end
        S_DSET: begin
          div_dsr <= DEN_W'({max_range, 1'b0});
          div_rem <= '0;
          div_dvd <= span_prod;
          div_quo <= '0;
          cnt     <= CNT_W'(DIV_N - 1);
          state   <= S_ODIV;
        end
        S_ODIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_PFIN;
          end
        end
        S_PFIN: begin
          res_pos <= pos_sat;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_pos   <= res_pos;
            out_est   <= EST_OUT_W'(est_int);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign samples.ready    = (state == S_IDLE);
  assign results.valid    = out_valid;
  assign results.position = out_pos;
  assign results.estimate = out_est;

endmodule
